// File: hdl/sfr_pkg.sv
`timescale 1ns / 1ps
// Package for the serial frame receiver: parser phase type, register indexes,
// frame kind codes, counter slots and the result word type. No dependencies.

package sfr_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } phase_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_TYPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_TYPE = 2'd2;

    localparam logic [7:0] START_BYTE_RESET = 8'hAA;
    localparam logic [7:0] MON_TYPE_RESET   = 8'h01;
    localparam logic [7:0] MOTOR_TYPE_RESET = 8'h02;

    localparam logic [1:0] KIND_MONITOR = 2'd0;
    localparam logic [1:0] KIND_MOTOR   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam int HEAD_DEPTH   = 4;
    localparam int NUM_COUNTERS = 5;
    localparam int CNT_COMPLETE = 0;
    localparam int CNT_MON      = 1;
    localparam int CNT_MOTOR    = 2;
    localparam int CNT_UNKNOWN  = 3;
    localparam int CNT_IGNORED  = 4;

    typedef struct packed {
        logic                               done;
        logic [1:0]                         kind;
        logic                               updated;
        logic [HEAD_DEPTH-1:0][7:0]         mon;
        logic [NUM_COUNTERS-1:0][31:0]      cnt;
    } result_t;

endpackage

// File: hdl/sfr_parser.sv
`timescale 1ns / 1ps
// Frame parser: phase state machine, payload head, monitoring fields,
// statistics counters and the configuration registers. Depends on sfr_pkg.

module sfr_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          accept,
    input  logic [7:0]                    rx_byte,
    output sfr_pkg::result_t              result
);

    sfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] start_reg;
    logic [7:0] mon_type_reg;
    logic [7:0] motor_type_reg;
    logic [7:0] exp_len_reg, exp_len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] idx_reg, idx_next;
    logic [sfr_pkg::HEAD_DEPTH-1:0][7:0]     head_reg, head_next;
    logic [sfr_pkg::HEAD_DEPTH-1:0][7:0]     mon_reg, mon_next;
    logic [sfr_pkg::NUM_COUNTERS-1:0][31:0]  cnt_reg, cnt_next;
    logic       done;
    logic [1:0] kind;
    logic       updated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= sfr_pkg::START_BYTE_RESET;
            mon_type_reg   <= sfr_pkg::MON_TYPE_RESET;
            motor_type_reg <= sfr_pkg::MOTOR_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfr_pkg::CFG_START_BYTE: start_reg      <= cfg_data;
                sfr_pkg::CFG_MON_TYPE:   mon_type_reg   <= cfg_data;
                sfr_pkg::CFG_MOTOR_TYPE: motor_type_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sfr_pkg::PH_WAIT;
            exp_len_reg <= '0;
            type_reg    <= '0;
            idx_reg     <= '0;
            head_reg    <= '0;
            mon_reg     <= '0;
            cnt_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            type_reg    <= type_next;
            idx_reg     <= idx_next;
            head_reg    <= head_next;
            mon_reg     <= mon_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        type_next    = type_reg;
        idx_next     = idx_reg;
        head_next    = head_reg;
        mon_next     = mon_reg;
        cnt_next     = cnt_reg;
        done         = 1'b0;
        kind         = sfr_pkg::KIND_MONITOR;
        updated      = 1'b0;
        unique case (phase_reg)
            sfr_pkg::PH_WAIT:
            begin
                if (rx_byte == start_reg)
                begin
                    phase_next = sfr_pkg::PH_LEN;
                end
                else
                begin
                    cnt_next[sfr_pkg::CNT_IGNORED] = cnt_reg[sfr_pkg::CNT_IGNORED] + 32'd1;
                end
            end
            sfr_pkg::PH_LEN:
            begin
                exp_len_next = rx_byte;
                phase_next   = sfr_pkg::PH_TYPE;
            end
            sfr_pkg::PH_TYPE:
            begin
                type_next  = rx_byte;
                idx_next   = '0;
                phase_next = (exp_len_reg == 8'd0) ? sfr_pkg::PH_CSUM : sfr_pkg::PH_DATA;
            end
            sfr_pkg::PH_DATA:
            begin
                if (idx_reg < 8'(sfr_pkg::HEAD_DEPTH))
                begin
                    head_next[idx_reg[1:0]] = rx_byte;
                end
                idx_next = idx_reg + 8'd1;
                if (idx_next >= exp_len_reg)
                begin
                    phase_next = sfr_pkg::PH_CSUM;
                end
            end
            sfr_pkg::PH_CSUM:
            begin
                done = 1'b1;
                cnt_next[sfr_pkg::CNT_COMPLETE] = cnt_reg[sfr_pkg::CNT_COMPLETE] + 32'd1;
                if (type_reg == mon_type_reg)
                begin
                    kind = sfr_pkg::KIND_MONITOR;
                    cnt_next[sfr_pkg::CNT_MON] = cnt_reg[sfr_pkg::CNT_MON] + 32'd1;
                    if (exp_len_reg >= 8'(sfr_pkg::HEAD_DEPTH))
                    begin
                        mon_next = head_reg;
                        updated  = 1'b1;
                    end
                end
                else if (type_reg == motor_type_reg)
                begin
                    kind = sfr_pkg::KIND_MOTOR;
                    cnt_next[sfr_pkg::CNT_MOTOR] = cnt_reg[sfr_pkg::CNT_MOTOR] + 32'd1;
                end
                else
                begin
                    kind = sfr_pkg::KIND_UNKNOWN;
                    cnt_next[sfr_pkg::CNT_UNKNOWN] = cnt_reg[sfr_pkg::CNT_UNKNOWN] + 32'd1;
                end
                phase_next   = sfr_pkg::PH_WAIT;
                idx_next     = '0;
                exp_len_next = '0;
                type_next    = '0;
            end
            default:
            begin
                phase_next = sfr_pkg::PH_WAIT;
            end
        endcase
    end

    always_comb
    begin
        result.done    = done;
        result.kind    = kind;
        result.updated = updated;
        result.mon     = mon_next;
        result.cnt     = cnt_next;
    end

endmodule

// File: hdl/sfr_out_stage.sv
`timescale 1ns / 1ps
// Result register with valid/ready handshake toward the consumer; it can take a
// new word whenever it is empty or its word is being taken. Depends on sfr_pkg.

module sfr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  sfr_pkg::result_t result_in,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output sfr_pkg::result_t result_out
);

    logic             valid_reg, valid_next;
    sfr_pkg::result_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

// File: hdl/serial_frame_receiver.sv
`timescale 1ns / 1ps
// Serial frame receiver, top level. Instantiates sfr_parser and sfr_out_stage;
// depends on sfr_pkg.
//
// The receiver parses a byte stream of frames laid out as start byte, length,
// type, payload and checksum, and returns one result word for every byte it
// takes. The parser updates its state in a single pass of logic and the result
// lands in an output register, so a new byte is accepted every cycle as long as
// the consumer takes results. The result word carries the frame-done flag and
// kind, the monitoring fields and all five wrapping counters with this byte's
// update applied. The checksum is not checked. Register writes take effect at
// once and are meant for idle times.

module serial_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_done,
    output logic [1:0]  frame_kind,
    output logic        monitor_updated,
    output logic [7:0]  dir_x,
    output logic [7:0]  dir_y,
    output logic [7:0]  omega,
    output logic [7:0]  speed_ratio,
    output logic [31:0] frames_complete,
    output logic [31:0] frames_monitoring,
    output logic [31:0] frames_motor,
    output logic [31:0] frames_unknown,
    output logic [31:0] bytes_ignored
);

    logic             accept;
    sfr_pkg::result_t parse_result;
    sfr_pkg::result_t held_result;

    assign accept = in_valid && in_ready;

    sfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .result    (parse_result)
    );

    sfr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (parse_result),
        .load_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (held_result)
    );

    assign frame_done        = held_result.done;
    assign frame_kind        = held_result.kind;
    assign monitor_updated   = held_result.updated;
    assign dir_x             = held_result.mon[0];
    assign dir_y             = held_result.mon[1];
    assign omega             = held_result.mon[2];
    assign speed_ratio       = held_result.mon[3];
    assign frames_complete   = held_result.cnt[sfr_pkg::CNT_COMPLETE];
    assign frames_monitoring = held_result.cnt[sfr_pkg::CNT_MON];
    assign frames_motor      = held_result.cnt[sfr_pkg::CNT_MOTOR];
    assign frames_unknown    = held_result.cnt[sfr_pkg::CNT_UNKNOWN];
    assign bytes_ignored     = held_result.cnt[sfr_pkg::CNT_IGNORED];

endmodule

// File: dv/sfr_checker.sv
`timescale 1ns / 1ps
// Checker for the serial frame receiver: watches the register port and both
// word channels, predicts every result word and compares it. Depends on sfr_pkg.

module sfr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        frame_done,
    input  logic [1:0]  frame_kind,
    input  logic        monitor_updated,
    input  logic [7:0]  dir_x,
    input  logic [7:0]  dir_y,
    input  logic [7:0]  omega,
    input  logic [7:0]  speed_ratio,
    input  logic [31:0] frames_complete,
    input  logic [31:0] frames_monitoring,
    input  logic [31:0] frames_motor,
    input  logic [31:0] frames_unknown,
    input  logic [31:0] bytes_ignored,
    output int          errors,
    output int          pending,
    output int          frames_seen
);

    logic [7:0]  start_code;
    logic [7:0]  mon_code;
    logic [7:0]  motor_code;

    sfr_pkg::phase_t phase;
    logic [7:0]  frame_len;
    logic [7:0]  frame_type;
    logic [7:0]  payload_pos;
    logic [7:0]  payload_head [sfr_pkg::HEAD_DEPTH];
    logic [7:0]  mon_fields [sfr_pkg::HEAD_DEPTH];
    logic [31:0] stats [sfr_pkg::NUM_COUNTERS];

    sfr_pkg::result_t expected_words [$];
    int          mismatches = 0;
    int          pending_words = 0;
    int          done_words = 0;

    assign errors      = mismatches;
    assign pending     = pending_words;
    assign frames_seen = done_words;

    function automatic sfr_pkg::result_t parse_byte(input logic [7:0] b);
        sfr_pkg::result_t w;
        w = '0;
        case (phase)
            sfr_pkg::PH_WAIT:
            begin
                if (b == start_code)
                    phase = sfr_pkg::PH_LEN;
                else
                    stats[sfr_pkg::CNT_IGNORED] = stats[sfr_pkg::CNT_IGNORED] + 32'd1;
            end
            sfr_pkg::PH_LEN:
            begin
                frame_len = b;
                phase = sfr_pkg::PH_TYPE;
            end
            sfr_pkg::PH_TYPE:
            begin
                frame_type = b;
                payload_pos = '0;
                phase = (frame_len == 8'd0) ? sfr_pkg::PH_CSUM : sfr_pkg::PH_DATA;
            end
            sfr_pkg::PH_DATA:
            begin
                if (payload_pos < 8'(sfr_pkg::HEAD_DEPTH))
                    payload_head[payload_pos[1:0]] = b;
                payload_pos = payload_pos + 8'd1;
                if (payload_pos >= frame_len)
                    phase = sfr_pkg::PH_CSUM;
            end
            sfr_pkg::PH_CSUM:
            begin
                w.done = 1'b1;
                stats[sfr_pkg::CNT_COMPLETE] = stats[sfr_pkg::CNT_COMPLETE] + 32'd1;
                if (frame_type == mon_code)
                begin
                    w.kind = sfr_pkg::KIND_MONITOR;
                    stats[sfr_pkg::CNT_MON] = stats[sfr_pkg::CNT_MON] + 32'd1;
                    if (frame_len >= 8'(sfr_pkg::HEAD_DEPTH))
                    begin
                        mon_fields = payload_head;
                        w.updated = 1'b1;
                    end
                end
                else if (frame_type == motor_code)
                begin
                    w.kind = sfr_pkg::KIND_MOTOR;
                    stats[sfr_pkg::CNT_MOTOR] = stats[sfr_pkg::CNT_MOTOR] + 32'd1;
                end
                else
                begin
                    w.kind = sfr_pkg::KIND_UNKNOWN;
                    stats[sfr_pkg::CNT_UNKNOWN] = stats[sfr_pkg::CNT_UNKNOWN] + 32'd1;
                end
                phase = sfr_pkg::PH_WAIT;
                payload_pos = '0;
                frame_len = '0;
                frame_type = '0;
            end
            default:
            begin
                phase = sfr_pkg::PH_WAIT;
            end
        endcase
        for (int i = 0; i < sfr_pkg::HEAD_DEPTH; i++)
            w.mon[i] = mon_fields[i];
        for (int i = 0; i < sfr_pkg::NUM_COUNTERS; i++)
            w.cnt[i] = stats[i];
        return w;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfr_pkg::result_t w;
        if (!rst_n)
        begin
            start_code  = sfr_pkg::START_BYTE_RESET;
            mon_code    = sfr_pkg::MON_TYPE_RESET;
            motor_code  = sfr_pkg::MOTOR_TYPE_RESET;
            phase       = sfr_pkg::PH_WAIT;
            frame_len   = '0;
            frame_type  = '0;
            payload_pos = '0;
            for (int i = 0; i < sfr_pkg::HEAD_DEPTH; i++)
            begin
                payload_head[i] = '0;
                mon_fields[i] = '0;
            end
            for (int i = 0; i < sfr_pkg::NUM_COUNTERS; i++)
                stats[i] = '0;
            expected_words.delete();
            pending_words = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sfr_pkg::CFG_START_BYTE: start_code = cfg_data;
                    sfr_pkg::CFG_MON_TYPE:   mon_code = cfg_data;
                    sfr_pkg::CFG_MOTOR_TYPE: motor_code = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word arrived with no byte waiting for it");
                    mismatches++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    compare_field("frame_done", 32'(w.done), 32'(frame_done));
                    compare_field("frame_kind", 32'(w.kind), 32'(frame_kind));
                    compare_field("monitor_updated", 32'(w.updated), 32'(monitor_updated));
                    compare_field("dir_x", 32'(w.mon[0]), 32'(dir_x));
                    compare_field("dir_y", 32'(w.mon[1]), 32'(dir_y));
                    compare_field("omega", 32'(w.mon[2]), 32'(omega));
                    compare_field("speed_ratio", 32'(w.mon[3]), 32'(speed_ratio));
                    compare_field("frames_complete", w.cnt[sfr_pkg::CNT_COMPLETE],
                                  frames_complete);
                    compare_field("frames_monitoring", w.cnt[sfr_pkg::CNT_MON],
                                  frames_monitoring);
                    compare_field("frames_motor", w.cnt[sfr_pkg::CNT_MOTOR], frames_motor);
                    compare_field("frames_unknown", w.cnt[sfr_pkg::CNT_UNKNOWN],
                                  frames_unknown);
                    compare_field("bytes_ignored", w.cnt[sfr_pkg::CNT_IGNORED],
                                  bytes_ignored);
                    if (w.done)
                        done_words++;
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(parse_byte(rx_byte));
            pending_words = expected_words.size();
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for serial_frame_receiver: clock, reset, byte and register stimulus,
// output back-pressure and the verdict; also depends on sfr_pkg and sfr_checker.

module tb;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = sfr_pkg::CFG_START_BYTE;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        frame_done;
    logic [1:0]  frame_kind;
    logic        monitor_updated;
    logic [7:0]  dir_x;
    logic [7:0]  dir_y;
    logic [7:0]  omega;
    logic [7:0]  speed_ratio;
    logic [31:0] frames_complete;
    logic [31:0] frames_monitoring;
    logic [31:0] frames_motor;
    logic [31:0] frames_unknown;
    logic [31:0] bytes_ignored;

    int          errors;
    int          pending;
    int          frames_seen;

    logic [7:0]  cur_start = sfr_pkg::START_BYTE_RESET;
    logic [7:0]  cur_mon = sfr_pkg::MON_TYPE_RESET;
    logic [7:0]  cur_motor = sfr_pkg::MOTOR_TYPE_RESET;
    logic        steady = 1'b0;
    int          bytes_sent = 0;
    int          settings_used = 1;
    int          stall_left = 0;

    always #10 clk = ~clk;

    serial_frame_receiver dut (.*);

    sfr_checker chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
    endtask

    task automatic write_regs(input logic [7:0] s, input logic [7:0] m, input logic [7:0] t);
        write_reg(sfr_pkg::CFG_START_BYTE, s);
        write_reg(sfr_pkg::CFG_MON_TYPE, m);
        write_reg(sfr_pkg::CFG_MOTOR_TYPE, t);
        write_reg(CFG_UNUSED, ~s);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_start = s;
        cur_mon = m;
        cur_motor = t;
        settings_used++;
    endtask

    task automatic send_random_frame();
        int noise;
        int len;
        int sel;
        logic [7:0] ftype;
        steady = ($urandom_range(0, 5) == 0);
        noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
        repeat (noise) send_byte(8'($urandom_range(0, 255)));
        len = ($urandom_range(0, 99) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 8);
        sel = $urandom_range(0, 9);
        ftype = (sel < 4) ? cur_mon : (sel < 7) ? cur_motor : 8'($urandom_range(0, 255));
        send_byte(cur_start);
        send_byte(8'(len));
        send_byte(ftype);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        logic [7:0] seq_a [23] = '{8'h00, 8'hFF,
                                   8'hAA, 8'h04, 8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h5A,
                                   8'hAA, 8'h00, 8'hFF, 8'h00,
                                   8'hAA, 8'h05, 8'h02, 8'hAA, 8'h01, 8'h02, 8'h03,
                                   8'h04, 8'hC3};
        logic [7:0] seq_b [7] = '{8'hAA, 8'h00, 8'h02, 8'h37, 8'h11, 8'h22, 8'h33};
        int phase_end;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first, then a start byte of zero with equal type codes.
        foreach (seq_a[i]) send_byte(seq_a[i]);
        settle();
        write_regs(8'h00, 8'h37, 8'h37);
        foreach (seq_b[i]) send_byte(seq_b[i]);

        for (int p = 0; p < 5; p++)
        begin
            settle();
            case (p)
                0: write_regs(sfr_pkg::START_BYTE_RESET, sfr_pkg::MON_TYPE_RESET,
                              sfr_pkg::MOTOR_TYPE_RESET);
                1: write_regs(8'hFF, 8'h00, 8'hFF);
                2: write_regs(8'h00, 8'hFF, 8'h00);
                default: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            phase_end = bytes_sent + 180;
            while (bytes_sent < phase_end) send_random_frame();
        end
        steady = 1'b0;
        settle();

        $display("tb: %0d bytes sent under %0d register settings, %0d frames completed",
                 bytes_sent, settings_used, frames_seen);
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: serial_frame_receiver.f
hdl/sfr_pkg.sv
hdl/sfr_parser.sv
hdl/sfr_out_stage.sv
hdl/serial_frame_receiver.sv
dv/sfr_checker.sv
dv/tb.sv
